/* rtl/core/gas_pkg.sv */
// Shared constants, codes and types of the greedy action selector.
package gas_pkg;

   localparam int MAX_WIDTH  = 32;
   localparam int MAX_HEIGHT = 32;
   localparam int HEADINGS   = 16;
   localparam int ACTIONS    = 4;

   localparam int X_W    = $clog2(MAX_WIDTH);
   localparam int Y_W    = $clog2(MAX_HEIGHT);
   localparam int H_W    = $clog2(HEADINGS);
   localparam int A_W    = $clog2(ACTIONS);
   localparam int VAL_W  = 16;
   localparam int MAP_W  = 6;
   localparam int STEP_W = 8;
   localparam int DH_W   = 5;

   localparam int CELL_AW = Y_W + X_W;
   localparam int VAL_AW  = CELL_AW + H_W;
   localparam int TR_AW   = A_W + H_W;

   localparam logic [VAL_W-1:0] PEN_BLOCK = 16'hFFFE;
   localparam logic [VAL_W-1:0] COST_NONE = 16'hFFFF;
   localparam logic [MAP_W-1:0] MAP_RESET = 6'd32;

   typedef enum logic [1:0] {
      OP_LOAD_VALUE   = 2'd0,
      OP_LOAD_PENALTY = 2'd1,
      OP_LOAD_TRANS   = 2'd2,
      OP_QUERY        = 2'd3
   } op_type;

   localparam logic REG_MAP_WIDTH  = 1'b0;
   localparam logic REG_MAP_HEIGHT = 1'b1;

   typedef struct packed {
      logic [DH_W-1:0]   dh;
      logic [STEP_W-1:0] dy;
      logic [STEP_W-1:0] dx;
   } trans_type;

   typedef struct packed {
      logic              ok;
      logic [VAL_AW-1:0] addr;
   } nbr_type;

endpackage

/* rtl/core/gas_neighbor.sv */
// Neighbor cell, heading wrap and map bounds check for one action.
module gas_neighbor (
   input  logic [gas_pkg::X_W-1:0]   cell_x,
   input  logic [gas_pkg::Y_W-1:0]   cell_y,
   input  logic [gas_pkg::H_W-1:0]   heading,
   input  gas_pkg::trans_type        step,
   input  logic [gas_pkg::MAP_W-1:0] width_lim,
   input  logic [gas_pkg::MAP_W-1:0] height_lim,
   output gas_pkg::nbr_type          nbr
);

   localparam int PX_W = (gas_pkg::X_W >= gas_pkg::STEP_W ? gas_pkg::X_W : gas_pkg::STEP_W) + 2;
   localparam int PY_W = (gas_pkg::Y_W >= gas_pkg::STEP_W ? gas_pkg::Y_W : gas_pkg::STEP_W) + 2;
   localparam int PH_W = (gas_pkg::H_W >= gas_pkg::DH_W ? gas_pkg::H_W : gas_pkg::DH_W) + 2;
   localparam logic signed [PH_W-1:0] NUM_H = PH_W'(gas_pkg::HEADINGS);

   logic signed [PX_W-1:0] nx;
   logic signed [PY_W-1:0] ny;
   logic signed [PH_W-1:0] nh_sum;
   logic signed [PH_W-1:0] nh_lo;
   logic signed [PH_W-1:0] nh;
   logic                   ok_x;
   logic                   ok_y;
   logic                   ok_h;

   always_comb begin
      nx = $signed(PX_W'(cell_x)) +
           $signed({{(PX_W-gas_pkg::STEP_W){step.dx[gas_pkg::STEP_W-1]}}, step.dx});
      ny = $signed(PY_W'(cell_y)) +
           $signed({{(PY_W-gas_pkg::STEP_W){step.dy[gas_pkg::STEP_W-1]}}, step.dy});
      nh_sum = $signed(PH_W'(heading)) +
               $signed({{(PH_W-gas_pkg::DH_W){step.dh[gas_pkg::DH_W-1]}}, step.dh});
      nh_lo = (nh_sum < 0) ? nh_sum + NUM_H : nh_sum;
      nh    = (nh_lo >= NUM_H) ? nh_lo - NUM_H : nh_lo;
      ok_x  = !nx[PX_W-1] && (nx < $signed(PX_W'(width_lim)));
      ok_y  = !ny[PY_W-1] && (ny < $signed(PY_W'(height_lim)));
      ok_h  = !nh[PH_W-1] && (nh < NUM_H);
      nbr.ok   = ok_x && ok_y && ok_h;
      nbr.addr = {ny[gas_pkg::Y_W-1:0], nx[gas_pkg::X_W-1:0], nh[gas_pkg::H_W-1:0]};
   end

endmodule

/* rtl/core/greedy_action_selector_unit.sv */
// Top level of the greedy action selector: stores, query sequencer and result register.
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  tuser op, tdata entry and transition fields
//  rsp      out        rsp_tvalid/rsp_tready  tdata best_action, blocked
//  csr      in         csr_we                 csr_index, csr_wdata
//
// A load request writes its store when it is accepted. A query runs from acceptance through
// the penalty check, then a scan step per action with the next transition read overlapped
// with the neighbor value compare. A query outside the map or on a blocked cell ends after
// the penalty check. Reset clears only the sequencer, the result valid flag and the map
// size registers; the stores hold nothing defined until loaded. A finished query waits in
// a holding state while the result register is still full.
module greedy_action_selector_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cell_x[4:0], cell_y[9:5], heading[13:10], entry_value[29:14], action_slot[31:30],
   // step_dx[39:32], step_dy[47:40], step_dheading[52:48], zero fill[55:53]
   input  logic [55:0] req_tdata,
   // op[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // best_action[1:0], blocked[2], zero fill[7:3]
   output logic [7:0]  rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [5:0]  csr_wdata
);

   localparam int A_W    = gas_pkg::A_W;
   localparam int H_W    = gas_pkg::H_W;
   localparam int VAL_W  = gas_pkg::VAL_W;
   localparam int MAP_W  = gas_pkg::MAP_W;
   localparam int TR_W   = $bits(gas_pkg::trans_type);
   localparam logic [MAP_W-1:0] WIDTH_CAP  = MAP_W'(gas_pkg::MAX_WIDTH);
   localparam logic [MAP_W-1:0] HEIGHT_CAP = MAP_W'(gas_pkg::MAX_HEIGHT);
   localparam logic [A_W-1:0]   LAST_ACT   = A_W'(gas_pkg::ACTIONS - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_HEAD,
      S_SCAN,
      S_OUT
   } state_type;

   gas_pkg::op_type          req_op;
   logic [gas_pkg::X_W-1:0]  req_x;
   logic [gas_pkg::Y_W-1:0]  req_y;
   logic [H_W-1:0]           req_h;
   logic [VAL_W-1:0]         req_value;
   logic [A_W-1:0]           req_slot;
   gas_pkg::trans_type       req_step;
   logic                     req_accept;

   assign req_op         = gas_pkg::op_type'(req_tuser);
   assign req_x          = req_tdata[4:0];
   assign req_y          = req_tdata[9:5];
   assign req_h          = req_tdata[13:10];
   assign req_value      = req_tdata[29:14];
   assign req_slot       = req_tdata[31:30];
   assign req_step.dx    = req_tdata[39:32];
   assign req_step.dy    = req_tdata[47:40];
   assign req_step.dh    = req_tdata[52:48];

   state_type                state_ff, state_in;
   logic [MAP_W-1:0]         map_width_ff, map_width_in;
   logic [MAP_W-1:0]         map_height_ff, map_height_in;
   logic [gas_pkg::X_W-1:0]  x_ff, x_in;
   logic [gas_pkg::Y_W-1:0]  y_ff, y_in;
   logic [H_W-1:0]           h_ff, h_in;
   logic                     qok_ff, qok_in;
   logic [A_W-1:0]           act_ff, act_in;
   logic [A_W-1:0]           cmp_act_ff, cmp_act_in;
   logic                     nb_ok_ff, nb_ok_in;
   logic [VAL_W-1:0]         min_cost_ff, min_cost_in;
   logic [A_W-1:0]           best_act_ff, best_act_in;
   logic [A_W-1:0]           res_act_ff, res_act_in;
   logic                     res_blk_ff, res_blk_in;
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [A_W-1:0]           rsp_act_ff, rsp_act_in;
   logic                     rsp_blk_ff, rsp_blk_in;

   logic [VAL_W-1:0]         value_mem [0:(1 << gas_pkg::VAL_AW)-1];
   logic [VAL_W-1:0]         penalty_mem [0:(1 << gas_pkg::CELL_AW)-1];
   logic [TR_W-1:0]          trans_mem [0:(1 << gas_pkg::TR_AW)-1];
   logic [VAL_W-1:0]         val_rd_ff;
   logic [VAL_W-1:0]         pen_rd_ff;
   gas_pkg::trans_type       trans_rd_ff;
   logic [gas_pkg::VAL_AW-1:0]  val_raddr;
   logic [gas_pkg::CELL_AW-1:0] pen_raddr;
   logic [gas_pkg::TR_AW-1:0]   tr_raddr;

   logic [MAP_W-1:0]         width_lim;
   logic [MAP_W-1:0]         height_lim;
   gas_pkg::nbr_type         nbr;
   logic [A_W-1:0]           act_next;
   logic                     slot_free;
   logic                     take;
   logic [VAL_W-1:0]         cost_upd;
   logic [A_W-1:0]           act_upd;

   assign width_lim  = (map_width_ff > WIDTH_CAP) ? WIDTH_CAP : map_width_ff;
   assign height_lim = (map_height_ff > HEIGHT_CAP) ? HEIGHT_CAP : map_height_ff;
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign act_next   = act_ff + 1'b1;
   assign slot_free  = !rsp_tvalid_ff || rsp_tready;

   gas_neighbor u_neighbor (
      .cell_x     (x_ff),
      .cell_y     (y_ff),
      .heading    (h_ff),
      .step       (trans_rd_ff),
      .width_lim  (width_lim),
      .height_lim (height_lim),
      .nbr        (nbr)
   );

   assign take     = nb_ok_ff && (val_rd_ff < min_cost_ff);
   assign cost_upd = take ? val_rd_ff : min_cost_ff;
   assign act_upd  = take ? cmp_act_ff : best_act_ff;

   always_comb begin
      state_in      = state_ff;
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      h_in          = h_ff;
      qok_in        = qok_ff;
      act_in        = act_ff;
      cmp_act_in    = cmp_act_ff;
      nb_ok_in      = nb_ok_ff;
      min_cost_in   = min_cost_ff;
      best_act_in   = best_act_ff;
      res_act_in    = res_act_ff;
      res_blk_in    = res_blk_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_act_in    = rsp_act_ff;
      rsp_blk_in    = rsp_blk_ff;
      val_raddr     = nbr.addr;
      pen_raddr     = {req_y, req_x};
      tr_raddr      = {act_next, h_ff};

      if (csr_we) begin
         case (csr_index)
            gas_pkg::REG_MAP_WIDTH:  map_width_in  = csr_wdata;
            gas_pkg::REG_MAP_HEIGHT: map_height_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            tr_raddr = {A_W'(0), req_h};
            if (req_accept && (req_op == gas_pkg::OP_QUERY)) begin
               x_in     = req_x;
               y_in     = req_y;
               h_in     = req_h;
               qok_in   = (MAP_W'(req_x) < width_lim) && (MAP_W'(req_y) < height_lim);
               act_in   = '0;
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            if (!qok_ff || (pen_rd_ff >= gas_pkg::PEN_BLOCK)) begin
               if (slot_free) begin
                  rsp_tvalid_in = 1'b1;
                  rsp_act_in    = '0;
                  rsp_blk_in    = qok_ff;
                  state_in      = S_IDLE;
               end else begin
                  res_act_in = '0;
                  res_blk_in = qok_ff;
                  state_in   = S_OUT;
               end
            end else begin
               nb_ok_in     = nbr.ok;
               cmp_act_in   = act_ff;
               act_in       = act_next;
               min_cost_in  = gas_pkg::COST_NONE;
               best_act_in  = '0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            min_cost_in  = cost_upd;
            best_act_in  = act_upd;
            if (cmp_act_ff == LAST_ACT) begin
               if (slot_free) begin
                  rsp_tvalid_in = 1'b1;
                  rsp_act_in    = act_upd;
                  rsp_blk_in    = 1'b0;
                  state_in      = S_IDLE;
               end else begin
                  res_act_in = act_upd;
                  res_blk_in = 1'b0;
                  state_in   = S_OUT;
               end
            end else begin
               nb_ok_in   = nbr.ok;
               cmp_act_in = act_ff;
               act_in     = act_next;
            end
         end
         S_OUT: begin
            if (slot_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_act_in    = res_act_ff;
               rsp_blk_in    = res_blk_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      h_ff         <= h_in;
      qok_ff       <= qok_in;
      act_ff       <= act_in;
      cmp_act_ff   <= cmp_act_in;
      nb_ok_ff     <= nb_ok_in;
      min_cost_ff  <= min_cost_in;
      best_act_ff  <= best_act_in;
      res_act_ff   <= res_act_in;
      res_blk_ff   <= res_blk_in;
      rsp_act_ff   <= rsp_act_in;
      rsp_blk_ff   <= rsp_blk_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
         map_width_ff  <= gas_pkg::MAP_RESET;
         map_height_ff <= gas_pkg::MAP_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && (req_op == gas_pkg::OP_LOAD_VALUE)) begin
         value_mem[{req_y, req_x, req_h}] <= req_value;
      end
      val_rd_ff <= value_mem[val_raddr];
   end

   always_ff @(posedge clock) begin
      if (req_accept && (req_op == gas_pkg::OP_LOAD_PENALTY)) begin
         penalty_mem[{req_y, req_x}] <= req_value;
      end
      pen_rd_ff <= penalty_mem[pen_raddr];
   end

   always_ff @(posedge clock) begin
      if (req_accept && (req_op == gas_pkg::OP_LOAD_TRANS)) begin
         trans_mem[{req_slot, req_h}] <= req_step;
      end
      trans_rd_ff <= trans_mem[tr_raddr];
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {5'b0, rsp_blk_ff, rsp_act_ff};

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_blk_ff) |-> (rsp_act_ff == '0))
      else $error("A blocked result carries a nonzero action.");

   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_op == gas_pkg::OP_QUERY)) |=> (state_ff == S_HEAD))
      else $error("An accepted query did not start the penalty check.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (act_ff == cmp_act_ff + 1'b1))
      else $error("Transition read is not one action ahead of the compare.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> rsp_tvalid_ff)
      else $error("Result is held back while the result register is empty.");
`endif

endmodule
